FILE: sv/cstu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Counting semaphore table package
// Shared codes, widths and types for the semaphore table front, queue and back.
// ----------------------------------------------------------------------------
package cstu_pkg;

  localparam int SEM_W          = 3;
  localparam int MAX_SEMS       = 8;
  localparam int SEMS_IN_USE_W  = 4;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 64;
  localparam int COUNT_BYTE     = 8;
  localparam int CNT_W          = 10;
  localparam int CNT_OUT_W      = 9;
  localparam int CNT_CEIL       = 255;
  localparam int QUEUE_SLOTS    = 2;

  localparam logic [SEMS_IN_USE_W-1:0] SEMS_IN_USE_RST = 4'd8;

  typedef enum logic [0:0] {
    CMD_WAIT   = 1'b0,
    CMD_SIGNAL = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_BLOCKED    = 2'd1,
    ST_NO_SEM     = 2'd2,
    ST_QUEUE_FULL = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SEMS_IN_USE = 2'd0,
    CFG_INIT_COUNTS = 2'd1
  } cfg_idx_e;

  typedef enum logic [0:0] {
    BK_EXEC = 1'b0,
    BK_RESP = 1'b1
  } back_state_e;

  typedef struct packed {
    logic                  valid;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } cfg_wr_t;

  typedef struct packed {
    cmd_e             cmd;
    logic [SEM_W-1:0] sem;
    logic             bad;
  } item_cls_t;

endpackage

FILE: sv/cstu_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Semaphore table front end
// Holds the in-use count and tags each incoming transaction with its command
// and whether the targeted semaphore exists.
// ----------------------------------------------------------------------------
module cstu_front #(
  parameter int NUM_SEMS = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  cstu_pkg::cfg_wr_t                 cfg_i,
  input  logic                              cmd_i,
  input  logic [cstu_pkg::SEM_W-1:0]        sem_index_i,
  output cstu_pkg::item_cls_t               cls_o
);
  import cstu_pkg::*;

  logic [SEMS_IN_USE_W-1:0] sems_in_use_q;
  logic [SEMS_IN_USE_W-1:0] sems_in_use_d;

  always_comb begin
    sems_in_use_d = sems_in_use_q;
    if (cfg_i.valid && (cfg_i.idx == CFG_SEMS_IN_USE)) begin
      sems_in_use_d = cfg_i.data[SEMS_IN_USE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sems_in_use_q <= SEMS_IN_USE_RST;
    end else begin
      sems_in_use_q <= sems_in_use_d;
    end
  end

  always_comb begin
    cls_o.cmd = cmd_e'(cmd_i);
    cls_o.sem = sem_index_i;
    cls_o.bad = ({1'b0, sem_index_i} >= sems_in_use_q) || (int'(sem_index_i) >= NUM_SEMS);
  end

endmodule

FILE: sv/cstu_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Semaphore table decoupling queue
// Short FIFO that carries tagged transactions from the front to the back end.
// ----------------------------------------------------------------------------
module cstu_queue #(
  parameter int WIDTH = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);
  import cstu_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_SLOTS);
  localparam int CNT_W_Q = $clog2(QUEUE_SLOTS + 1);

  logic [WIDTH-1:0]   slot_q [QUEUE_SLOTS];
  logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CNT_W_Q-1:0] level_q;
  logic               do_push, do_pop;

  assign full_o  = (level_q == CNT_W_Q'(QUEUE_SLOTS));
  assign empty_o = (level_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_SLOTS - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_SLOTS - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        level_q <= level_q + CNT_W_Q'(1);
      end else if (do_pop && !do_push) begin
        level_q <= level_q - CNT_W_Q'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

FILE: sv/cstu_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Semaphore table back end
// Read-modify-write of one semaphore count and its wait queue per transaction,
// with the waiter store in a memory and a registered result stage.
// ----------------------------------------------------------------------------
module cstu_back #(
  parameter int NUM_SEMS    = 8,
  parameter int QUEUE_DEPTH = 16,
  parameter int PID_BITS    = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  cstu_pkg::cfg_wr_t                 cfg_i,
  input  logic                              q_empty_i,
  input  cstu_pkg::item_cls_t               q_cls_i,
  input  logic [PID_BITS-1:0]               q_pid_i,
  output logic                              q_pop_o,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output cstu_pkg::status_e                 status_o,
  output logic                              woken_valid_o,
  output logic [PID_BITS-1:0]               woken_pid_o,
  output logic [cstu_pkg::CNT_OUT_W-1:0]    count_after_o
);
  import cstu_pkg::*;

  localparam int SEMS      = (NUM_SEMS < MAX_SEMS) ? NUM_SEMS : MAX_SEMS;
  localparam int SIDX_W    = (SEMS > 1) ? $clog2(SEMS) : 1;
  localparam int PTR_W     = $clog2(QUEUE_DEPTH);
  localparam int FILL_W    = $clog2(QUEUE_DEPTH + 1);
  localparam int MEM_DEPTH = SEMS * QUEUE_DEPTH;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  localparam logic signed [CNT_W-1:0] CNT_ZERO = '0;
  localparam logic signed [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic signed [CNT_W-1:0] CNT_TOP  = CNT_W'(CNT_CEIL);

  logic signed [CNT_W-1:0] count_q [SEMS];
  logic [PTR_W-1:0]        head_q  [SEMS];
  logic [PTR_W-1:0]        tail_q  [SEMS];
  logic [FILL_W-1:0]       fill_q  [SEMS];
  logic [PID_BITS-1:0]     waiter_mem [MEM_DEPTH];
  logic [PID_BITS-1:0]     rdata_q;

  back_state_e state_q, state_d;
  logic        exec_go, load_out;

  logic [SIDX_W-1:0]       sel;
  logic signed [CNT_W-1:0] cnt, cnt_inc, cnt_nxt;
  logic [PTR_W-1:0]        head, tail, head_inc, tail_inc, head_nxt, tail_nxt, ptr;
  logic [FILL_W-1:0]       fill, fill_nxt;
  status_e                 res_status;
  logic                    res_wv, mem_we, mem_re;
  logic [CNT_OUT_W-1:0]    res_cnt;
  logic [ADDR_W-1:0]       mem_addr;

  status_e              res_status_q;
  logic                 res_wv_q;
  logic [CNT_OUT_W-1:0] res_cnt_q;

  logic                 out_valid_q;
  status_e              status_q;
  logic                 woken_valid_q;
  logic [PID_BITS-1:0]  woken_pid_q;
  logic [CNT_OUT_W-1:0] count_after_q;

  always_comb begin
    state_d  = state_q;
    exec_go  = 1'b0;
    load_out = 1'b0;
    unique case (state_q)
      BK_EXEC: begin
        if (!q_empty_i) begin
          exec_go = 1'b1;
          state_d = BK_RESP;
        end
      end
      BK_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          load_out = 1'b1;
          state_d  = BK_EXEC;
        end
      end
      default: state_d = BK_EXEC;
    endcase
  end

  assign q_pop_o = exec_go;

  always_comb begin
    sel      = q_cls_i.sem[SIDX_W-1:0];
    cnt      = count_q[sel];
    head     = head_q[sel];
    tail     = tail_q[sel];
    fill     = fill_q[sel];
    cnt_inc  = (cnt < CNT_TOP) ? cnt + CNT_ONE : cnt;
    head_inc = (head == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head + PTR_W'(1);
    tail_inc = (tail == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail + PTR_W'(1);

    cnt_nxt    = cnt;
    head_nxt   = head;
    tail_nxt   = tail;
    fill_nxt   = fill;
    ptr        = tail;
    res_status = ST_OK;
    res_wv     = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;

    if (q_cls_i.bad) begin
      res_status = ST_NO_SEM;
    end else if (q_cls_i.cmd == CMD_WAIT) begin
      if (cnt > CNT_ZERO) begin
        cnt_nxt = cnt - CNT_ONE;
      end else if (fill == FILL_W'(QUEUE_DEPTH)) begin
        res_status = ST_QUEUE_FULL;
      end else begin
        mem_we     = exec_go;
        tail_nxt   = tail_inc;
        fill_nxt   = fill + FILL_W'(1);
        cnt_nxt    = cnt - CNT_ONE;
        res_status = ST_BLOCKED;
      end
    end else begin
      cnt_nxt = cnt_inc;
      if ((cnt_inc <= CNT_ZERO) && (fill != '0)) begin
        mem_re   = exec_go;
        ptr      = head;
        head_nxt = head_inc;
        fill_nxt = fill - FILL_W'(1);
        res_wv   = 1'b1;
      end
    end

    res_cnt  = q_cls_i.bad ? '0 : cnt_nxt[CNT_OUT_W-1:0];
    mem_addr = ADDR_W'(int'(sel) * QUEUE_DEPTH + int'(ptr));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_EXEC;
      out_valid_q <= 1'b0;
      for (int i = 0; i < SEMS; i++) begin
        count_q[i] <= '0;
        head_q[i]  <= '0;
        tail_q[i]  <= '0;
        fill_q[i]  <= '0;
      end
    end else begin
      state_q <= state_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_i.valid && (cfg_i.idx == CFG_INIT_COUNTS)) begin
        for (int i = 0; i < SEMS; i++) begin
          count_q[i] <= CNT_W'(cfg_i.data[COUNT_BYTE*i +: COUNT_BYTE]);
          head_q[i]  <= '0;
          tail_q[i]  <= '0;
          fill_q[i]  <= '0;
        end
      end else if (exec_go && !q_cls_i.bad) begin
        count_q[sel] <= cnt_nxt;
        head_q[sel]  <= head_nxt;
        tail_q[sel]  <= tail_nxt;
        fill_q[sel]  <= fill_nxt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      waiter_mem[mem_addr] <= q_pid_i;
    end
    if (mem_re) begin
      rdata_q <= waiter_mem[mem_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_go) begin
      res_status_q <= res_status;
      res_wv_q     <= res_wv;
      res_cnt_q    <= res_cnt;
    end
    if (load_out) begin
      status_q      <= res_status_q;
      woken_valid_q <= res_wv_q;
      woken_pid_q   <= res_wv_q ? rdata_q : '0;
      count_after_q <= res_cnt_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign woken_valid_o = woken_valid_q;
  assign woken_pid_o   = woken_pid_q;
  assign count_after_o = count_after_q;

endmodule

FILE: sv/counting_semaphore_table_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Counting semaphore table unit
// Table of counting semaphores, each with a FIFO of blocked process ids.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o) takes one wait or signal transaction
// with a semaphore index and caller pid. Output channel (out_valid_o /
// out_stall_i) returns exactly one result per transaction, in order: status,
// the woken pid for a signal that releases a waiter, and the count after.
// Configuration writes (cfg_valid_i / cfg_ready_o) set the number of
// semaphores in use (index 0) or reload all counts and empty all wait queues
// (index 1); issue them only while the unit is idle.
// The back end handles a transaction in an execute state, doing the count/queue
// read-modify-write with the waiter memory access and registering the result and
// memory read data, then in a response state that loads the output registers; it
// takes no new transaction before that. A two-entry queue decouples the front
// end, so input keeps flowing while a result waits; when out_stall_i holds, the
// back end stops after finishing its current transaction and the queue fills.
// Reset empties every wait queue, sets all counts to zero and eight semaphores
// in use; the waiter memory needs no clearing.
// ----------------------------------------------------------------------------
module counting_semaphore_table_unit #(
  parameter int NUM_SEMS    = 8,
  parameter int QUEUE_DEPTH = 16,
  parameter int PID_BITS    = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [cstu_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [cstu_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                cmd_i,
  input  logic [cstu_pkg::SEM_W-1:0]          sem_index_i,
  input  logic [PID_BITS-1:0]                 pid_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output cstu_pkg::status_e                   status_o,
  output logic                                woken_valid_o,
  output logic [PID_BITS-1:0]                 woken_pid_o,
  output logic [cstu_pkg::CNT_OUT_W-1:0]      count_after_o
);
  import cstu_pkg::*;

  localparam int Q_W = $bits(item_cls_t) + PID_BITS;

  cfg_wr_t             cfg;
  item_cls_t           front_cls, q_cls;
  logic [PID_BITS-1:0] q_pid;
  logic [Q_W-1:0]      q_din, q_dout;
  logic                q_full, q_empty, q_pop;

  assign cfg_ready_o = 1'b1;
  assign cfg.valid   = cfg_valid_i && cfg_ready_o;
  assign cfg.idx     = cfg_index_i;
  assign cfg.data    = cfg_data_i;

  cstu_front #(
    .NUM_SEMS (NUM_SEMS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .cmd_i       (cmd_i),
    .sem_index_i (sem_index_i),
    .cls_o       (front_cls)
  );

  assign q_din      = {front_cls, pid_i};
  assign in_stall_o = q_full;

  cstu_queue #(
    .WIDTH (Q_W)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_valid_i),
    .data_i  (q_din),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .data_o  (q_dout),
    .empty_o (q_empty)
  );

  assign {q_cls, q_pid} = q_dout;

  cstu_back #(
    .NUM_SEMS    (NUM_SEMS),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .PID_BITS    (PID_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .q_empty_i     (q_empty),
    .q_cls_i       (q_cls),
    .q_pid_i       (q_pid),
    .q_pop_o       (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .woken_valid_o (woken_valid_o),
    .woken_pid_o   (woken_pid_o),
    .count_after_o (count_after_o)
  );

  a_pid_zero_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !woken_valid_o |-> woken_pid_o == '0)
    else $error("woken pid nonzero without a woken process");

  a_wake_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && woken_valid_o |-> status_o == ST_OK)
    else $error("woken process reported with non-ok status");

  a_no_sem_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_NO_SEM) |-> count_after_o == '0 && !woken_valid_o)
    else $error("invalid semaphore result carries state");

  a_blocked_negative: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_BLOCKED) |-> count_after_o[CNT_OUT_W-1])
    else $error("blocked caller with non-negative count");

endmodule
